// ===== hdl/u8d_pkg.sv =====
// Shared types, constants and the lead byte classifier for the UTF-8 sequence decoder.
// Depends on nothing; the lane, merge and decoder files refer to it by scoped names.
package u8d_pkg;

  localparam int unsigned NUM_CONT = 5;   // continuation bytes that one item can carry
  localparam int unsigned CP_W     = 31;
  localparam int unsigned LEN_W    = 3;

  localparam logic [LEN_W-1:0] LEN_BAD   = 3'd0;
  localparam logic [LEN_W-1:0] LEN_ONE   = 3'd1;
  localparam logic [LEN_W-1:0] LEN_TWO   = 3'd2;
  localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
  localparam logic [LEN_W-1:0] LEN_FOUR  = 3'd4;
  localparam logic [LEN_W-1:0] LEN_FIVE  = 3'd5;
  localparam logic [LEN_W-1:0] LEN_SIX   = 3'd6;

  localparam logic [7:0] CONT_MASK = 8'hC0;
  localparam logic [7:0] CONT_TAG  = 8'h80;

  // What one lane finds in its byte.
  typedef struct packed {
    logic       is_cont;
    logic [5:0] bits;
  } lane_t;

  typedef lane_t [NUM_CONT-1:0] lane_vec_t;

  typedef struct packed {
    logic [CP_W-1:0]  code_point;
    logic [LEN_W-1:0] used_bytes;
  } result_t;

  // Sequence length from the lead byte; leads 0xFE and 0xFF count as six.
  function automatic logic [LEN_W-1:0] lead_len(input logic [7:0] lead);
    logic [LEN_W-1:0] len;
    if (lead < 8'h80)      len = LEN_ONE;
    else if (lead < 8'hC0) len = LEN_BAD;
    else if (lead < 8'hE0) len = LEN_TWO;
    else if (lead < 8'hF0) len = LEN_THREE;
    else if (lead < 8'hF8) len = LEN_FOUR;
    else if (lead < 8'hFC) len = LEN_FIVE;
    else                   len = LEN_SIX;
    return len;
  endfunction

endpackage

// ===== hdl/u8d_if.sv =====
// Valid/ready channel interfaces for the decoder's input and result items.
// Depends on nothing but the language; payload widths are those of the item fields.
interface u8d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] lead_byte;
  logic [7:0] second_byte;
  logic [7:0] third_byte;
  logic [7:0] fourth_byte;
  logic [7:0] fifth_byte;
  logic [7:0] sixth_byte;

  modport source (output valid, lead_byte, second_byte, third_byte, fourth_byte,
                  fifth_byte, sixth_byte, input ready);
  modport sink (input valid, lead_byte, second_byte, third_byte, fourth_byte,
                fifth_byte, sixth_byte, output ready);
endinterface

interface u8d_out_if;
  logic        valid;
  logic        ready;
  logic [30:0] code_point;
  logic [2:0]  used_bytes;

  modport source (output valid, code_point, used_bytes, input ready);
  modport sink (input valid, code_point, used_bytes, output ready);
endinterface

// ===== hdl/u8d_lane.sv =====
// One continuation lane: checks the 10xxxxxx tag of a byte and extracts its payload bits.
// Depends on u8d_pkg.
module u8d_lane (
  input  logic [7:0]    byte_in,
  output u8d_pkg::lane_t lane
);

  assign lane.is_cont = ((byte_in & u8d_pkg::CONT_MASK) == u8d_pkg::CONT_TAG);
  assign lane.bits    = byte_in[5:0];

endmodule

// ===== hdl/u8d_merge.sv =====
// Merging stage: classifies the lead byte, checks the lanes the length needs and packs
// the code point. Depends on u8d_pkg.
module u8d_merge (
  input  logic [7:0]          lead_byte,
  input  u8d_pkg::lane_vec_t  lanes,
  output u8d_pkg::result_t    result
);

  logic [u8d_pkg::LEN_W-1:0]    len;
  logic [u8d_pkg::NUM_CONT-1:0] need;
  logic [u8d_pkg::NUM_CONT-1:0] cont_ok;
  logic                         all_ok;
  logic [u8d_pkg::CP_W-1:0]     packed_cp;

  assign len = u8d_pkg::lead_len(lead_byte);

  // Lane i holds byte i+2 of the sequence and matters only when the length reaches it.
  always_comb begin
    for (int i = 0; i < u8d_pkg::NUM_CONT; i++) begin
      need[i]    = ({1'b0, len} >= 4'(i + 2));
      cont_ok[i] = lanes[i].is_cont;
    end
  end

  assign all_ok = &(cont_ok | ~need);

  always_comb begin
    case (len)
      u8d_pkg::LEN_ONE:   packed_cp = {24'd0, lead_byte[6:0]};
      u8d_pkg::LEN_TWO:   packed_cp = {20'd0, lead_byte[4:0], lanes[0].bits};
      u8d_pkg::LEN_THREE: packed_cp = {15'd0, lead_byte[3:0], lanes[0].bits, lanes[1].bits};
      u8d_pkg::LEN_FOUR:  packed_cp = {10'd0, lead_byte[2:0], lanes[0].bits, lanes[1].bits,
                                       lanes[2].bits};
      u8d_pkg::LEN_FIVE:  packed_cp = {5'd0, lead_byte[1:0], lanes[0].bits, lanes[1].bits,
                                       lanes[2].bits, lanes[3].bits};
      u8d_pkg::LEN_SIX:   packed_cp = {lead_byte[0], lanes[0].bits, lanes[1].bits,
                                       lanes[2].bits, lanes[3].bits, lanes[4].bits};
      default:            packed_cp = '0;
    endcase
  end

  always_comb begin
    if (all_ok) begin
      result.code_point = packed_cp;
      result.used_bytes = len;
    end else begin
      result.code_point = '0;
      result.used_bytes = u8d_pkg::LEN_BAD;
    end
  end

endmodule

// ===== hdl/utf8_sequence_decoder.sv =====
// UTF-8 sequence decoder: one whole sequence of up to six bytes per item.
// An accepted item's result is registered in the output register, or in the skid entry if that is full.
// Throughput: one item per cycle while input ready is high; five lanes check the continuation bytes in parallel.
// A two-entry output buffer keeps input ready while one result waits to be taken.
// Reset (rst_n, synchronous, active low) empties the output buffer; the result data registers are not reset.
// Depends on u8d_pkg, u8d_if, u8d_lane and u8d_merge.
module utf8_sequence_decoder (
  input  logic      clk,
  input  logic      rst_n,
  u8d_in_if.sink    in_ch,
  u8d_out_if.source out_ch
);

  logic [7:0]         cont_bytes [u8d_pkg::NUM_CONT];
  u8d_pkg::lane_vec_t lanes;
  u8d_pkg::result_t   new_res;

  assign cont_bytes[0] = in_ch.second_byte;
  assign cont_bytes[1] = in_ch.third_byte;
  assign cont_bytes[2] = in_ch.fourth_byte;
  assign cont_bytes[3] = in_ch.fifth_byte;
  assign cont_bytes[4] = in_ch.sixth_byte;

  for (genvar g = 0; g < u8d_pkg::NUM_CONT; g++) begin : g_lane
    u8d_lane u_lane (
      .byte_in (cont_bytes[g]),
      .lane    (lanes[g])
    );
  end

  u8d_merge u_merge (
    .lead_byte (in_ch.lead_byte),
    .lanes     (lanes),
    .result    (new_res)
  );

  // Output register plus skid entry.
  logic             out_valid_r, out_valid_nxt;
  logic             skid_valid_r, skid_valid_nxt;
  u8d_pkg::result_t out_res_r, out_res_nxt;
  u8d_pkg::result_t skid_res_r, skid_res_nxt;
  logic             accept;
  logic             take;

  assign in_ch.ready = !skid_valid_r;
  assign accept      = in_ch.valid && in_ch.ready;
  assign take        = out_valid_r && out_ch.ready;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_res_nxt    = out_res_r;
    skid_res_nxt   = skid_res_r;
    if (!out_valid_r || take) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_res_nxt    = skid_res_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = accept;
        out_res_nxt   = new_res;
      end
    end else if (accept) begin
      skid_valid_nxt = 1'b1;
      skid_res_nxt   = new_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.code_point = out_res_r.code_point;
  assign out_ch.used_bytes = out_res_r.used_bytes;

endmodule
